// ----- hdl/block_average_mosaic_top_defines.svh -----
// assertion macros for the block average mosaic top level
// expects i_clk and i_rst_n in the scope of each use
`ifndef BLOCK_AVERAGE_MOSAIC_TOP_DEFINES_SVH
`define BLOCK_AVERAGE_MOSAIC_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BAM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bam same-cycle check failed");

// next-cycle implication, checked out of reset
`define BAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bam next-cycle check failed");

`endif

// ----- hdl/bam_pkg.sv -----
// shared types and constants of the block average mosaic
// used by bam_lane, bam_merge and block_average_mosaic_top
package bam_pkg;

    localparam int PIX_W        = 8;
    localparam int PIX_MAX      = (1 << PIX_W) - 1;
    localparam int LANES        = 3;
    localparam int COORD_W      = 10;
    localparam int CFG_BS_W     = 7;
    localparam int CFG_DIM_W    = 11;
    localparam int ROW_W        = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * COORD_W - LANES * PIX_W;

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_BS_W-1:0]  BS_RESET = 7'd8;
    localparam logic [CFG_DIM_W-1:0] W_RESET  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] H_RESET  = 11'd480;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_res_tag;

endpackage

// ----- hdl/bam_lane.sv -----
// one channel lane: running block sum update and bit-serial floor divide
// depends on bam_pkg
module bam_lane #(
    parameter int SUM_W = 20,
    parameter int AR_W  = 14
) (
    input  logic                       i_clk,
    input  logic [bam_pkg::PIX_W-1:0]  i_pix,
    input  logic [SUM_W-1:0]           i_sum_rd,
    input  logic                       i_first,
    input  logic [AR_W-1:0]            i_area,
    input  bam_pkg::t_lane_ctl         i_ctl,
    output logic [SUM_W-1:0]           o_sum,
    output logic [bam_pkg::PIX_W-1:0]  o_avg
);

    logic [AR_W-1:0]  r_div;
    logic [AR_W-1:0]  r_rem;
    logic [SUM_W-1:0] r_quo;

    logic [AR_W:0]    w_trial;
    logic [AR_W:0]    w_diff;
    logic             w_ge;
    logic [AR_W-1:0]  n_rem;

    assign o_sum = i_first ? SUM_W'(i_pix) : i_sum_rd + SUM_W'(i_pix);

    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[AR_W-1:0] : w_trial[AR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_div <= i_area;
            r_rem <= '0;
            r_quo <= o_sum;
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    assign o_avg = r_quo[bam_pkg::PIX_W-1:0];

endmodule

// ----- hdl/bam_merge.sv -----
// merge stage: joins the lane averages with the block tag into the output register
// depends on bam_pkg
module bam_merge (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  logic [bam_pkg::LANES-1:0][bam_pkg::PIX_W-1:0] i_avg,
    input  bam_pkg::t_res_tag                            i_tag,
    input  logic                                         i_tready,
    output logic                                         o_tvalid,
    output logic [bam_pkg::OUT_TDATA_W-1:0]              o_tdata,
    output logic                                         o_tlast,
    output logic                                         o_free
);

    logic                            r_valid;
    logic                            n_valid;
    logic [bam_pkg::OUT_TDATA_W-1:0] r_data;
    logic                            r_last;

    assign o_free = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {{bam_pkg::OUT_PAD_W{1'b0}}, i_avg, i_tag.row, i_tag.col};
            r_last <= i_tag.last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// ----- hdl/block_average_mosaic_top.sv -----
// Block average mosaic. For each pixel, the accept cycle reads the block column's
// sums from the single-port sum memory, and the next cycle updates and writes them
// back. A pixel that completes a block adds a bit-serial division of SUM_W quotient
// bits in the three channel lanes (SUM_W is 20 at the default MAX_BLOCK) and a
// hand-off into the output register, which the consumer may hold before taking it.
// The sum memory needs no clearing after reset. Depends on bam_pkg, bam_lane,
// bam_merge and block_average_mosaic_top_defines.svh.
`include "block_average_mosaic_top_defines.svh"

module block_average_mosaic_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bam_pkg::APB_AW-1:0]         paddr,
    input  logic [bam_pkg::APB_DW-1:0]         pwdata,
    output logic [bam_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_channel, second_channel, third_channel
    input  logic [bam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // frame_start
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // block_column, block_row, average_first, average_second, average_third, zero pad
    output logic [bam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // frame_done
    output logic                               m_axis_tlast
);

    localparam int XW    = ($clog2(MAX_WIDTH + 1) > bam_pkg::CFG_DIM_W) ?
                           $clog2(MAX_WIDTH + 1) : bam_pkg::CFG_DIM_W;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int BSW   = $clog2(MAX_BLOCK + 1);
    localparam int BXW   = (BSW > bam_pkg::CFG_BS_W) ? BSW : bam_pkg::CFG_BS_W;
    localparam int CBW   = $clog2(MAX_BLOCK);
    localparam int AR_W  = 2 * BSW;
    localparam int SUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * bam_pkg::PIX_MAX + 1);
    localparam int CNT_W = $clog2(SUM_W);
    localparam int XPW   = XW + 1 + BSW;
    localparam int YPW   = bam_pkg::ROW_W + 1 + BSW;
    localparam int RW    = bam_pkg::ROW_W;

    // configuration
    logic [bam_pkg::CFG_BS_W-1:0]  r_block_size;
    logic [bam_pkg::CFG_DIM_W-1:0] r_image_width;
    logic [bam_pkg::CFG_DIM_W-1:0] r_image_height;
    logic                          w_cfg_wr;
    logic [1:0]                    w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= bam_pkg::BS_RESET;
            r_image_width  <= bam_pkg::W_RESET;
            r_image_height <= bam_pkg::H_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                bam_pkg::REG_BLOCK_SIZE:   r_block_size   <= pwdata[bam_pkg::CFG_BS_W-1:0];
                bam_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[bam_pkg::CFG_DIM_W-1:0];
                bam_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[bam_pkg::CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            bam_pkg::REG_BLOCK_SIZE:   prdata = bam_pkg::APB_DW'(r_block_size);
            bam_pkg::REG_IMAGE_WIDTH:  prdata = bam_pkg::APB_DW'(r_image_width);
            bam_pkg::REG_IMAGE_HEIGHT: prdata = bam_pkg::APB_DW'(r_image_height);
            default:                   prdata = '0;
        endcase
    end

    // clamped settings
    logic [BXW-1:0] w_bs_x;
    logic [BXW-1:0] w_bs_c;
    logic [BSW-1:0] w_bs;
    logic [XW-1:0]  w_wx;
    logic [XW-1:0]  w_w;
    logic [RW-1:0]  w_h;

    always_comb begin
        w_bs_x = BXW'(r_block_size);
        if (w_bs_x == '0) begin
            w_bs_c = BXW'(1);
        end else if (w_bs_x > BXW'(MAX_BLOCK)) begin
            w_bs_c = BXW'(MAX_BLOCK);
        end else begin
            w_bs_c = w_bs_x;
        end
        w_bs = w_bs_c[BSW-1:0];

        w_wx = XW'(r_image_width);
        if (w_wx == '0) begin
            w_w = XW'(1);
        end else if (w_wx > XW'(MAX_WIDTH)) begin
            w_w = XW'(MAX_WIDTH);
        end else begin
            w_w = w_wx;
        end

        if (r_image_height == '0) begin
            w_h = RW'(1);
        end else if (r_image_height > RW'(bam_pkg::HEIGHT_LIMIT)) begin
            w_h = RW'(bam_pkg::HEIGHT_LIMIT);
        end else begin
            w_h = r_image_height;
        end
    end

    // sequencer
    bam_pkg::t_state    r_state;
    bam_pkg::t_state    n_state;
    bam_pkg::t_lane_ctl w_ctl;
    logic               w_merge_load;
    logic               w_free;
    logic               w_acc;
    logic               w_emit;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_cnt_last;

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cnt_last = (r_cnt == CNT_W'(SUM_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bam_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = bam_pkg::S_ACC;
                end
            end
            bam_pkg::S_ACC: begin
                n_state = w_emit ? bam_pkg::S_DIV : bam_pkg::S_IDLE;
            end
            bam_pkg::S_DIV: begin
                if (w_cnt_last) begin
                    n_state = bam_pkg::S_DONE;
                end
            end
            bam_pkg::S_DONE: begin
                if (w_free) begin
                    n_state = bam_pkg::S_IDLE;
                end
            end
            default: n_state = bam_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_ctl         = '0;
        w_merge_load  = 1'b0;
        unique case (r_state)
            bam_pkg::S_IDLE: s_axis_tready = 1'b1;
            bam_pkg::S_ACC:  w_ctl.load    = w_emit;
            bam_pkg::S_DIV:  w_ctl.step    = 1'b1;
            bam_pkg::S_DONE: w_merge_load  = w_free;
            default: ;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_ctl.load) begin
            n_cnt = '0;
        end else if (w_ctl.step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bam_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // position counters
    logic [XW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [CBW-1:0] r_cib;
    logic [CBW-1:0] r_rib;
    logic [XW-1:0]  r_cbc;
    logic [RW-1:0]  r_cbr;
    logic [XW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic [CBW-1:0] n_cib;
    logic [CBW-1:0] n_rib;
    logic [XW-1:0]  n_cbc;
    logic [RW-1:0]  n_cbr;
    logic [XW-1:0]  w_cbc_e;
    logic [RW-1:0]  w_cbr_e;
    logic [BSW:0]   w_cib_i;
    logic [BSW:0]   w_rib_i;
    logic [XW:0]    w_col_i;
    logic [RW:0]    w_row_i;

    assign w_cbc_e = s_axis_tuser ? '0 : r_cbc;
    assign w_cbr_e = s_axis_tuser ? '0 : r_cbr;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_cib   = r_cib;
        n_rib   = r_rib;
        n_cbc   = r_cbc;
        n_cbr   = r_cbr;
        w_cib_i = (BSW + 1)'(r_cib) + (BSW + 1)'(1);
        w_rib_i = (BSW + 1)'(r_rib) + (BSW + 1)'(1);
        w_col_i = (XW + 1)'(r_col) + (XW + 1)'(1);
        w_row_i = (RW + 1)'(r_row) + (RW + 1)'(1);
        if (w_acc && s_axis_tuser) begin
            n_col = '0;
            n_row = '0;
            n_cib = '0;
            n_rib = '0;
            n_cbc = '0;
            n_cbr = '0;
        end else if (r_state == bam_pkg::S_ACC) begin
            if (w_cib_i >= (BSW + 1)'(w_bs)) begin
                n_cib = '0;
                n_cbc = r_cbc + XW'(1);
            end else begin
                n_cib = w_cib_i[CBW-1:0];
            end
            if (w_col_i >= (XW + 1)'(w_w)) begin
                n_col = '0;
                n_cib = '0;
                n_cbc = '0;
                n_row = w_row_i[RW-1:0];
                if (w_rib_i >= (BSW + 1)'(w_bs)) begin
                    n_rib = '0;
                    n_cbr = r_cbr + RW'(1);
                end else begin
                    n_rib = w_rib_i[CBW-1:0];
                end
                if (w_row_i >= (RW + 1)'(w_h)) begin
                    n_row = '0;
                    n_rib = '0;
                    n_cbr = '0;
                end
            end else begin
                n_col = w_col_i[XW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cib <= '0;
            r_rib <= '0;
            r_cbc <= '0;
            r_cbr <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_cib <= n_cib;
            r_rib <= n_rib;
            r_cbc <= n_cbc;
            r_cbr <= n_cbr;
        end
    end

    // request capture and block limits
    logic [bam_pkg::IN_TDATA_W-1:0] r_px;
    logic [XPW-1:0]                 r_xp1;
    logic [XPW-1:0]                 r_xp2;
    logic [YPW-1:0]                 r_yp1;
    logic [YPW-1:0]                 r_yp2;
    logic [AR_W-1:0]                r_area;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px   <= s_axis_tdata;
            r_xp1  <= (XPW'(w_cbc_e) + XPW'(1)) * XPW'(w_bs);
            r_xp2  <= (XPW'(w_cbc_e) + XPW'(2)) * XPW'(w_bs);
            r_yp1  <= (YPW'(w_cbr_e) + YPW'(1)) * YPW'(w_bs);
            r_yp2  <= (YPW'(w_cbr_e) + YPW'(2)) * YPW'(w_bs);
            r_area <= AR_W'(w_bs) * AR_W'(w_bs);
        end
    end

    logic w_blk;
    logic w_first;
    logic w_end;
    logic w_last_blk;

    always_comb begin
        w_blk      = (r_xp1 <= XPW'(w_w)) && (r_yp1 <= YPW'(w_h));
        w_last_blk = (r_xp2 > XPW'(w_w)) && (r_yp2 > YPW'(w_h));
        w_first    = (r_rib == '0) && (r_cib == '0);
        w_end      = (BSW'(r_rib) == w_bs - BSW'(1)) && (BSW'(r_cib) == w_bs - BSW'(1));
        w_emit     = (r_state == bam_pkg::S_ACC) && w_blk && w_end;
    end

    // block column sum memory
    logic [bam_pkg::LANES*SUM_W-1:0]              r_mem [MAX_WIDTH];
    logic [bam_pkg::LANES-1:0][SUM_W-1:0]         r_rd;
    logic [bam_pkg::LANES-1:0][SUM_W-1:0]         w_sum;
    logic [bam_pkg::LANES-1:0][bam_pkg::PIX_W-1:0] w_avg;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= r_mem[w_cbc_e[AW-1:0]];
        end
        if ((r_state == bam_pkg::S_ACC) && w_blk) begin
            r_mem[r_cbc[AW-1:0]] <= w_sum;
        end
    end

    for (genvar g = 0; g < bam_pkg::LANES; g++) begin : g_lane
        bam_lane #(
            .SUM_W (SUM_W),
            .AR_W  (AR_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_pix    (r_px[g*bam_pkg::PIX_W +: bam_pkg::PIX_W]),
            .i_sum_rd (r_rd[g]),
            .i_first  (w_first),
            .i_area   (r_area),
            .i_ctl    (w_ctl),
            .o_sum    (w_sum[g]),
            .o_avg    (w_avg[g])
        );
    end

    // result tag
    bam_pkg::t_res_tag r_tag;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_tag.col  <= r_cbc[bam_pkg::COORD_W-1:0];
            r_tag.row  <= r_cbr[bam_pkg::COORD_W-1:0];
            r_tag.last <= w_last_blk;
        end
    end

    bam_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_merge_load),
        .i_avg    (w_avg),
        .i_tag    (r_tag),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_free   (w_free)
    );

    // checks
    `BAM_ASSERT_NEXT(a_accept_to_acc, w_acc, r_state == bam_pkg::S_ACC)
    `BAM_ASSERT_NEXT(a_load_starts_div, w_ctl.load, (r_state == bam_pkg::S_DIV) && (r_cnt == '0))
    `BAM_ASSERT_NEXT(a_div_ends, (r_state == bam_pkg::S_DIV) && w_cnt_last, r_state == bam_pkg::S_DONE)
    `BAM_ASSERT_SAME(a_no_accept_busy, r_state != bam_pkg::S_IDLE, !s_axis_tready)

endmodule

// ----- test/tb_block_average_mosaic_top.sv -----
// testbench for block_average_mosaic_top: streams raster pixels under many block and
// image settings and checks every block average against a built-in prediction
// depends on bam_pkg and block_average_mosaic_top
`timescale 1ns / 1ps

module tb_block_average_mosaic_top;

    localparam int MOSAIC_COLS   = 1024;
    localparam int MOSAIC_BLOCK  = 64;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_PIXELS = 360;

    typedef struct {
        logic [bam_pkg::PIX_W-1:0] ch [3];
        logic                      frame_start;
    } t_pixel;

    typedef struct packed {
        logic [bam_pkg::COORD_W-1:0] col;
        logic [bam_pkg::COORD_W-1:0] row;
        logic [bam_pkg::PIX_W-1:0]   avg0;
        logic [bam_pkg::PIX_W-1:0]   avg1;
        logic [bam_pkg::PIX_W-1:0]   avg2;
        logic                        done;
    } t_block_avg;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [bam_pkg::APB_AW-1:0]      paddr = '0;
    logic [bam_pkg::APB_DW-1:0]      pwdata = '0;
    logic [bam_pkg::APB_DW-1:0]      prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bam_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bam_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    block_average_mosaic_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    // pending pixels and predicted block averages
    t_pixel     pixel_q [$];
    t_block_avg avg_q [$];

    // predictor copy of configuration and state
    logic [bam_pkg::CFG_BS_W-1:0]  cfg_bs = bam_pkg::BS_RESET;
    logic [bam_pkg::CFG_DIM_W-1:0] cfg_w = bam_pkg::W_RESET;
    logic [bam_pkg::CFG_DIM_W-1:0] cfg_h = bam_pkg::H_RESET;
    int unsigned col_sum [MOSAIC_COLS][3];
    bit          col_written [MOSAIC_COLS];
    int unsigned px_col, px_row, col_in_blk, row_in_blk, blk_col, blk_row;

    int  err_count = 0;
    int  pixels_sent = 0;
    int  settings_used = 0;
    int  blocks_seen = 0;
    int  frames_seen = 0;
    int  cycle_count = 0;
    int  hold_trigger = 0;
    int  hold_seen = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    t_pixel     tx_pix;
    t_block_avg rx_want, rx_got;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 99) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void mosaic_limits(output int unsigned bs, output int unsigned w,
                                          output int unsigned h, output int unsigned nbx,
                                          output int unsigned nby);
        bs  = clamp_range(cfg_bs, 1, MOSAIC_BLOCK);
        w   = clamp_range(cfg_w, 1, MOSAIC_COLS);
        h   = clamp_range(cfg_h, 1, bam_pkg::HEIGHT_LIMIT);
        nbx = w / bs;
        nby = h / bs;
    endfunction

    function automatic void clear_counters();
        px_col = 0;
        px_row = 0;
        col_in_blk = 0;
        row_in_blk = 0;
        blk_col = 0;
        blk_row = 0;
    endfunction

    // true when the next pixel would add to a column sum that was never loaded
    function automatic bit touches_unloaded();
        int unsigned bs, w, h, nbx, nby;
        mosaic_limits(bs, w, h, nbx, nby);
        return blk_col < nbx && blk_row < nby && !(row_in_blk == 0 && col_in_blk == 0)
            && !col_written[blk_col];
    endfunction

    function automatic void predict_average(input t_pixel p);
        int unsigned bs, w, h, nbx, nby, area;
        bit          first;
        t_block_avg  res;
        mosaic_limits(bs, w, h, nbx, nby);
        if (p.frame_start) clear_counters();
        if (blk_col < nbx && blk_row < nby && blk_col < MOSAIC_COLS) begin
            first = (row_in_blk == 0 && col_in_blk == 0);
            for (int c = 0; c < 3; c++) begin
                col_sum[blk_col][c] = first ? p.ch[c] : col_sum[blk_col][c] + p.ch[c];
            end
            col_written[blk_col] = 1'b1;
            if (row_in_blk == bs - 1 && col_in_blk == bs - 1) begin
                area = bs * bs;
                res.col  = 10'(blk_col);
                res.row  = 10'(blk_row);
                res.avg0 = 8'(col_sum[blk_col][0] / area);
                res.avg1 = 8'(col_sum[blk_col][1] / area);
                res.avg2 = 8'(col_sum[blk_col][2] / area);
                res.done = (blk_col + 1 == nbx && blk_row + 1 == nby);
                avg_q.push_back(res);
            end
        end
        px_col++;
        col_in_blk++;
        if (col_in_blk >= bs) begin
            col_in_blk = 0;
            blk_col++;
        end
        if (px_col >= w) begin
            px_col = 0;
            col_in_blk = 0;
            blk_col = 0;
            px_row++;
            row_in_blk++;
            if (row_in_blk >= bs) begin
                row_in_blk = 0;
                blk_row++;
            end
            if (px_row >= h) clear_counters();
        end
    endfunction

    function automatic void push_pixel(input t_pixel p);
        if (!p.frame_start && touches_unloaded()) p.frame_start = 1'b1;
        predict_average(p);
        pixel_q.push_back(p);
        pixels_sent++;
    endfunction

    function automatic void push_rgb(input int b, input int g, input int r, input bit fs);
        t_pixel p;
        p.ch[0] = 8'(b);
        p.ch[1] = 8'(g);
        p.ch[2] = 8'(r);
        p.frame_start = fs;
        push_pixel(p);
    endfunction

    function automatic t_pixel rand_pixel(input bit fs);
        t_pixel p;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) p.ch[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else p.ch[k] = 8'($urandom_range(0, 255));
        end
        p.frame_start = fs;
        return p;
    endfunction

    function automatic int check_field(input string name, input int unsigned want,
                                       input int unsigned got);
        if (want == got) return 0;
        $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        return 1;
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pixel_q.size() != 0 || s_tvalid || avg_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mosaic(input int bs, input int w, input int h);
        wait_drain();
        apb_write(bam_pkg::REG_BLOCK_SIZE, 32'(bs));
        apb_write(bam_pkg::REG_IMAGE_WIDTH, 32'(w));
        apb_write(bam_pkg::REG_IMAGE_HEIGHT, 32'(h));
        cfg_bs = 7'(bs);
        cfg_w  = 11'(w);
        cfg_h  = 11'(h);
        settings_used++;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_phase(input int bs, input int w, input int h, input int n,
                             input bit fs_first, input int fs_rate, input bit hold);
        bit fs;
        set_mosaic(bs, w, h);
        if (hold) hold_trigger++;
        for (int i = 0; i < n; i++) begin
            fs = (i == 0) ? fs_first : (fs_rate != 0 && $urandom_range(1, fs_rate) == 1);
            push_pixel(rand_pixel(fs));
        end
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap != 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (pixel_q.size() != 0) begin
                tx_pix = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {tx_pix.ch[2], tx_pix.ch[1], tx_pix.ch[0]};
                s_tuser  <= tx_pix.frame_start;
                tx_gap   <= tx_steady ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // block average monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            rx_stall  <= 0;
            hold_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_got.col  = m_tdata[bam_pkg::COORD_W-1:0];
                rx_got.row  = m_tdata[2*bam_pkg::COORD_W-1:bam_pkg::COORD_W];
                rx_got.avg0 = m_tdata[2*bam_pkg::COORD_W+bam_pkg::PIX_W-1:
                                      2*bam_pkg::COORD_W];
                rx_got.avg1 = m_tdata[2*bam_pkg::COORD_W+2*bam_pkg::PIX_W-1:
                                      2*bam_pkg::COORD_W+bam_pkg::PIX_W];
                rx_got.avg2 = m_tdata[2*bam_pkg::COORD_W+3*bam_pkg::PIX_W-1:
                                      2*bam_pkg::COORD_W+2*bam_pkg::PIX_W];
                rx_got.done = m_tlast;
                blocks_seen++;
                if (m_tlast) frames_seen++;
                if (avg_q.size() == 0) begin
                    $display("%0t ns: unexpected block average col %0d row %0d", $time,
                             rx_got.col, rx_got.row);
                    err_count++;
                end else begin
                    rx_want = avg_q.pop_front();
                    err_count += check_field("block_column", rx_want.col, rx_got.col);
                    err_count += check_field("block_row", rx_want.row, rx_got.row);
                    err_count += check_field("average_first", rx_want.avg0, rx_got.avg0);
                    err_count += check_field("average_second", rx_want.avg1, rx_got.avg1);
                    err_count += check_field("average_third", rx_want.avg2, rx_got.avg2);
                    err_count += check_field("frame_done", rx_want.done, rx_got.done);
                end
            end
            if (hold_seen != hold_trigger) begin
                hold_seen <= hold_trigger;
                rx_stall  <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall <= rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d averages outstanding", $time, avg_q.size());
            $display("block_average_mosaic_top: mismatch");
            $finish;
        end
    end

    initial begin
        int bs, w, h, rand_start;
        clear_counters();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one 2x2 block with an ignored column, a wrapped frame, a restart mid-frame
        set_mosaic(2, 3, 2);
        push_rgb(0, 0, 0, 1);
        push_rgb(255, 255, 255, 0);
        push_rgb(0, 255, 0, 0);
        push_rgb(255, 0, 255, 0);
        push_rgb(255, 255, 255, 0);
        push_rgb(0, 0, 0, 0);
        for (int i = 0; i < 6; i++) push_rgb(255, 255, 255, 0);
        push_rgb(1, 2, 3, 0);
        push_rgb(4, 5, 6, 0);
        push_rgb(7, 8, 9, 1);
        // zero sizes taken as one, changed mid-frame
        set_mosaic(0, 0, 0);
        push_rgb(255, 0, 128, 0);
        push_rgb(0, 255, 1, 0);
        push_rgb(128, 128, 128, 0);
        push_rgb(255, 255, 255, 0);
        // image smaller than one block
        set_mosaic(5, 4, 4);
        push_rgb(255, 255, 255, 1);
        for (int i = 0; i < 4; i++) push_rgb(0, 0, 0, 0);

        // saturated block size, width and height
        run_phase(127, 64, 64, 60, 1'b1, 0, 1'b0);
        run_phase(1, 2047, 1, 60, 1'b1, 0, 1'b1);
        run_phase(1, 1, 2047, 60, 1'b0, 0, 1'b0);

        rand_start = pixels_sent;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            bs = $urandom_range(1, 6);
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, bs) : $urandom_range(bs, 24);
            h  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, bs) : $urandom_range(bs, 10);
            run_phase(bs, w, h, $urandom_range(20, 90), $urandom_range(0, 1), 80,
                      $urandom_range(0, 9) == 0);
        end

        wait_drain();
        $display("covered %0d pixels under %0d settings, block sizes 1 to 64 with saturation",
                 pixels_sent, settings_used);
        $display("checked %0d block averages, %0d of them ending a frame",
                 blocks_seen, frames_seen);
        if (err_count == 0) begin
            $display("block_average_mosaic_top: match");
        end else begin
            $display("block_average_mosaic_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- block_average_mosaic_top.f -----
+incdir+hdl
hdl/bam_pkg.sv
hdl/bam_lane.sv
hdl/bam_merge.sv
hdl/block_average_mosaic_top.sv
test/tb_block_average_mosaic_top.sv
